// ----- hw/rtl/aabb_frustum_cull_defines.svh -----
// Assertion macros shared by the frustum cull checker.
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define AFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define AFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/afc_pkg.sv -----
// Types and constants shared by the frustum cull modules.
package afc_pkg;

  localparam int NORM_W   = 16;
  localparam int COORD_W  = 32;
  localparam int OFFSET_W = 32;
  localparam int PROD_W   = NORM_W + COORD_W;
  localparam int ACC_W    = PROD_W + 2;
  // Offset is Q16.16 and products are Q2.14 * Q16.16, so the offset is aligned by 14 bits.
  localparam int OFFSET_SHIFT = 14;
  localparam int AXES     = 3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_FIRST = 2'd0;
  localparam logic [STEP_W-1:0] STEP_AX1   = 2'd1;
  localparam logic [STEP_W-1:0] STEP_AX2   = 2'd2;
  localparam logic [STEP_W-1:0] STEP_LAST  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } afc_state_e;

  typedef struct packed {
    logic clear;   // load the accumulator with the aligned plane offset
    logic accum;   // add the held product into the accumulator
    logic mul_en;  // capture a new product
  } mac_ctrl_t;

endpackage

// ----- hw/rtl/afc_mac.sv -----
// Shared multiply-accumulate unit that evaluates one plane distance term at a time.
module afc_mac (
  input  logic                                clk_i,
  input  afc_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [afc_pkg::NORM_W-1:0]   norm_i,
  input  logic signed [afc_pkg::COORD_W-1:0]  coord_i,
  input  logic signed [afc_pkg::OFFSET_W-1:0] offset_i,
  output logic                                sum_neg_o
);

  logic signed [afc_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [afc_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [afc_pkg::ACC_W-1:0]  sum;

  always_comb begin
    prod_d = afc_pkg::PROD_W'(norm_i) * afc_pkg::PROD_W'(coord_i);
  end

  // The running sum including the product still held in the register.
  assign sum = acc_q + afc_pkg::ACC_W'(prod_q);
  assign sum_neg_o = sum[afc_pkg::ACC_W-1];

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = afc_pkg::ACC_W'(offset_i) <<< afc_pkg::OFFSET_SHIFT;
    end else if (ctrl_i.accum) begin
      acc_d = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

endmodule

// ----- hw/rtl/aabb_frustum_cull.sv -----
// Box-against-frustum cull: a load transaction stores one plane and gives no result; a test
// transaction runs in the sequencer (three products and one final accumulate and sign check
// per plane through one shared 16x32 multiplier), then posts the result and returns to idle,
// where ready is high again; no new transaction is taken before that. A result that is not
// taken holds the block in the post state.
// A plane culls when 2^14*d + sum of n*c < 0, where c is the max corner coordinate for a
// non-negative normal component and the min corner otherwise; this equals the doubled
// center/extent test exactly. Planes never loaded hold zero and never cull.
module aabb_frustum_cull #(
  parameter int PLANE_COUNT = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [2:0]                          plane_index_i,
  input  logic signed [afc_pkg::NORM_W-1:0]   normal_x_i,
  input  logic signed [afc_pkg::NORM_W-1:0]   normal_y_i,
  input  logic signed [afc_pkg::NORM_W-1:0]   normal_z_i,
  input  logic signed [afc_pkg::OFFSET_W-1:0] plane_offset_i,
  input  logic signed [afc_pkg::COORD_W-1:0]  box_min_x_i,
  input  logic signed [afc_pkg::COORD_W-1:0]  box_min_y_i,
  input  logic signed [afc_pkg::COORD_W-1:0]  box_min_z_i,
  input  logic signed [afc_pkg::COORD_W-1:0]  box_max_x_i,
  input  logic signed [afc_pkg::COORD_W-1:0]  box_max_y_i,
  input  logic signed [afc_pkg::COORD_W-1:0]  box_max_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                visible_o
);

  localparam int IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam logic [IDX_W-1:0] PLANE_LAST = IDX_W'(PLANE_COUNT - 1);

  afc_pkg::afc_state_e state_q, state_d;

  logic signed [afc_pkg::NORM_W-1:0]   normal_q [PLANE_COUNT][afc_pkg::AXES];
  logic signed [afc_pkg::OFFSET_W-1:0] offset_q [PLANE_COUNT];
  logic signed [afc_pkg::COORD_W-1:0]  lo_q [afc_pkg::AXES];
  logic signed [afc_pkg::COORD_W-1:0]  hi_q [afc_pkg::AXES];

  logic [IDX_W-1:0]           plane_q, plane_d;
  logic [afc_pkg::STEP_W-1:0] step_q, step_d;
  logic                       cull_q, cull_d;
  logic                       out_valid_q, out_valid_d;
  logic                       visible_q, visible_d;

  logic                                in_accept;
  logic                                load_ok;
  afc_pkg::mac_ctrl_t                  mac_ctrl;
  logic signed [afc_pkg::NORM_W-1:0]   mac_norm;
  logic signed [afc_pkg::COORD_W-1:0]  mac_coord;
  logic                                mac_neg;

  assign in_accept = in_valid_i && in_ready_o;
  assign load_ok   = (32'(plane_index_i) < PLANE_COUNT);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      afc_pkg::ST_IDLE: begin
        if (in_valid_i && (kind_i == afc_pkg::KIND_TEST)) begin
          state_d = afc_pkg::ST_RUN;
        end
      end
      afc_pkg::ST_RUN: begin
        if ((step_q == afc_pkg::STEP_LAST) && (plane_q == PLANE_LAST)) begin
          state_d = afc_pkg::ST_WAIT;
        end
      end
      afc_pkg::ST_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = afc_pkg::ST_IDLE;
        end
      end
      default: state_d = afc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    mac_ctrl   = '0;
    unique case (state_q)
      afc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      afc_pkg::ST_RUN: begin
        mac_ctrl.clear  = (step_q == afc_pkg::STEP_FIRST);
        mac_ctrl.accum  = (step_q == afc_pkg::STEP_AX1) || (step_q == afc_pkg::STEP_AX2);
        mac_ctrl.mul_en = (step_q != afc_pkg::STEP_LAST);
      end
      afc_pkg::ST_WAIT: begin
        in_ready_o = 1'b0;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Operand select: the corner that lies farthest along the normal component.
  always_comb begin
    case (step_q)
      afc_pkg::STEP_FIRST: mac_norm = normal_q[plane_q][0];
      afc_pkg::STEP_AX1:   mac_norm = normal_q[plane_q][1];
      afc_pkg::STEP_AX2:   mac_norm = normal_q[plane_q][2];
      default:             mac_norm = '0;
    endcase
    case (step_q)
      afc_pkg::STEP_FIRST: mac_coord = mac_norm[afc_pkg::NORM_W-1] ? lo_q[0] : hi_q[0];
      afc_pkg::STEP_AX1:   mac_coord = mac_norm[afc_pkg::NORM_W-1] ? lo_q[1] : hi_q[1];
      afc_pkg::STEP_AX2:   mac_coord = mac_norm[afc_pkg::NORM_W-1] ? lo_q[2] : hi_q[2];
      default:             mac_coord = '0;
    endcase
  end

  afc_mac u_mac (
    .clk_i     (clk_i),
    .ctrl_i    (mac_ctrl),
    .norm_i    (mac_norm),
    .coord_i   (mac_coord),
    .offset_i  (offset_q[plane_q]),
    .sum_neg_o (mac_neg)
  );

  // Counters, cull flag and result register.
  always_comb begin
    step_d      = step_q;
    plane_d     = plane_q;
    cull_d      = cull_q;
    out_valid_d = out_valid_q;
    visible_d   = visible_q;

    if (in_accept && (kind_i == afc_pkg::KIND_TEST)) begin
      step_d  = afc_pkg::STEP_FIRST;
      plane_d = '0;
      cull_d  = 1'b0;
    end

    if (state_q == afc_pkg::ST_RUN) begin
      step_d = step_q + afc_pkg::STEP_W'(1);
      if (step_q == afc_pkg::STEP_LAST) begin
        plane_d = plane_q + IDX_W'(1);
        cull_d  = cull_q | mac_neg;
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == afc_pkg::ST_WAIT) && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
      visible_d   = !cull_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afc_pkg::ST_IDLE;
      step_q      <= '0;
      plane_q     <= '0;
      cull_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      plane_q     <= plane_d;
      cull_q      <= cull_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Plane store clears on reset, since an unloaded plane must read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int a = 0; a < afc_pkg::AXES; a++) begin
          normal_q[p][a] <= '0;
        end
        offset_q[p] <= '0;
      end
    end else if (in_accept && (kind_i == afc_pkg::KIND_LOAD) && load_ok) begin
      normal_q[plane_index_i[IDX_W-1:0]][0] <= normal_x_i;
      normal_q[plane_index_i[IDX_W-1:0]][1] <= normal_y_i;
      normal_q[plane_index_i[IDX_W-1:0]][2] <= normal_z_i;
      offset_q[plane_index_i[IDX_W-1:0]]    <= plane_offset_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && (kind_i == afc_pkg::KIND_TEST)) begin
      lo_q[0] <= box_min_x_i;
      lo_q[1] <= box_min_y_i;
      lo_q[2] <= box_min_z_i;
      hi_q[0] <= box_max_x_i;
      hi_q[1] <= box_max_y_i;
      hi_q[2] <= box_max_z_i;
    end
    visible_q <= visible_d;
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

endmodule

// ----- hw/rtl/afc_checker.sv -----
// Port-level checks for the frustum cull block, bound to its top level.
`include "aabb_frustum_cull_defines.svh"

module afc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic kind_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic visible_o
);

  logic in_take;
  logic test_take;
  logic load_take;
  logic out_stall;

  assign in_take   = in_valid_i && in_ready_o;
  assign test_take = in_take && (kind_i == afc_pkg::KIND_TEST);
  assign load_take = in_take && (kind_i == afc_pkg::KIND_LOAD);
  assign out_stall = out_valid_o && !out_ready_i;

  `AFC_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(visible_o), "held result changed")
  `AFC_ASSERT_NXT(a_test_busy, test_take, !in_ready_o, "ready while a test was running")
  `AFC_ASSERT_NXT(a_load_silent, load_take && !out_valid_o, !out_valid_o, "load gave a result")
  `AFC_ASSERT_IMP(a_result_src, $rose(out_valid_o), !$past(in_ready_o), "result without a test")

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .visible_o   (visible_o)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the box-against-frustum cull block.
`timescale 1ns / 100ps

module tb;

  localparam int NORM_W   = afc_pkg::NORM_W;
  localparam int COORD_W  = afc_pkg::COORD_W;
  localparam int OFFSET_W = afc_pkg::OFFSET_W;
  localparam int AXES     = afc_pkg::AXES;

  localparam int PLANES     = 6;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 40;
  localparam int PHASE_LEN  = 325;

  // Plane slots.
  localparam logic [2:0] PL_LEFT   = 3'd0;
  localparam logic [2:0] PL_RIGHT  = 3'd1;
  localparam logic [2:0] PL_BOTTOM = 3'd2;
  localparam logic [2:0] PL_TOP    = 3'd3;
  localparam logic [2:0] PL_NEAR   = 3'd4;
  localparam logic [2:0] PL_FAR    = 3'd5;
  localparam logic [2:0] PL_SPARE6 = 3'd6;
  localparam logic [2:0] PL_SPARE7 = 3'd7;

  typedef struct packed {
    logic                       kind;
    logic [2:0]                 plane_idx;
    logic signed [NORM_W-1:0]   nx;
    logic signed [NORM_W-1:0]   ny;
    logic signed [NORM_W-1:0]   nz;
    logic signed [OFFSET_W-1:0] offset;
    logic signed [COORD_W-1:0]  min_x;
    logic signed [COORD_W-1:0]  min_y;
    logic signed [COORD_W-1:0]  min_z;
    logic signed [COORD_W-1:0]  max_x;
    logic signed [COORD_W-1:0]  max_y;
    logic signed [COORD_W-1:0]  max_z;
  } cull_item_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic                       kind_i         = afc_pkg::KIND_LOAD;
  logic [2:0]                 plane_index_i  = '0;
  logic signed [NORM_W-1:0]   normal_x_i     = '0;
  logic signed [NORM_W-1:0]   normal_y_i     = '0;
  logic signed [NORM_W-1:0]   normal_z_i     = '0;
  logic signed [OFFSET_W-1:0] plane_offset_i = '0;
  logic signed [COORD_W-1:0]  box_min_x_i    = '0;
  logic signed [COORD_W-1:0]  box_min_y_i    = '0;
  logic signed [COORD_W-1:0]  box_min_z_i    = '0;
  logic signed [COORD_W-1:0]  box_max_x_i    = '0;
  logic signed [COORD_W-1:0]  box_max_y_i    = '0;
  logic signed [COORD_W-1:0]  box_max_z_i    = '0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic                       visible_o;

  // Shadow copy of the plane store, kept in step with accepted loads.
  logic [NORM_W-1:0]   shadow_norm [PLANES][AXES];
  logic [OFFSET_W-1:0] shadow_off  [PLANES];

  logic expected_visible [$];
  logic want_visible;
  int   mismatches = 0;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   stall_hold = 0;
  int   cycle_count = 0;

  aabb_frustum_cull #(
    .PLANE_COUNT(PLANES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .plane_index_i (plane_index_i),
    .normal_x_i    (normal_x_i),
    .normal_y_i    (normal_y_i),
    .normal_z_i    (normal_z_i),
    .plane_offset_i(plane_offset_i),
    .box_min_x_i   (box_min_x_i),
    .box_min_y_i   (box_min_y_i),
    .box_min_z_i   (box_min_z_i),
    .box_max_x_i   (box_max_x_i),
    .box_max_y_i   (box_max_y_i),
    .box_max_z_i   (box_max_z_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .visible_o     (visible_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL aabb_frustum_cull");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Doubled center/extent test: a plane culls when s < -r, both exact in 64 bits.
  function automatic logic predict_visible(input cull_item_t it);
    longint lo [AXES];
    longint hi [AXES];
    longint n;
    longint s;
    longint r;
    logic   culled;
    lo[0] = longint'(it.min_x);
    lo[1] = longint'(it.min_y);
    lo[2] = longint'(it.min_z);
    hi[0] = longint'(it.max_x);
    hi[1] = longint'(it.max_y);
    hi[2] = longint'(it.max_z);
    culled = 1'b0;
    for (int p = 0; p < PLANES; p++) begin
      s = longint'($signed(shadow_off[p])) * 32768;
      r = 0;
      for (int a = 0; a < AXES; a++) begin
        n = longint'($signed(shadow_norm[p][a]));
        s += n * (lo[a] + hi[a]);
        r += ((n < 0) ? -n : n) * (hi[a] - lo[a]);
      end
      if (s < -r) culled = 1'b1;
    end
    return !culled;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_visible.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want_visible = expected_visible.pop_front();
        if (visible_o !== want_visible) begin
          report_mismatch($sformatf("visible got %b expected %b", visible_o, want_visible));
        end
      end
    end
    // Most stalls are not extended; now and then one becomes a long hold.
    if (stall_hold != 0) begin
      stall_hold  <= stall_hold - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready_i <= 1'b0;
      stall_hold  <= ($urandom_range(3) == 0) ? $urandom_range(1, 30) : 0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Valid stays high between back-to-back transactions; it only drops for a gap.
  task automatic send_item(input cull_item_t it);
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= it.kind;
    plane_index_i  <= it.plane_idx;
    normal_x_i     <= it.nx;
    normal_y_i     <= it.ny;
    normal_z_i     <= it.nz;
    plane_offset_i <= it.offset;
    box_min_x_i    <= it.min_x;
    box_min_y_i    <= it.min_y;
    box_min_z_i    <= it.min_z;
    box_max_x_i    <= it.max_x;
    box_max_y_i    <= it.max_y;
    box_max_z_i    <= it.max_z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (it.kind == afc_pkg::KIND_TEST) begin
      expected_visible = {expected_visible, predict_visible(it)};
    end else if (it.plane_idx < PLANES) begin
      shadow_norm[it.plane_idx][0] = it.nx;
      shadow_norm[it.plane_idx][1] = it.ny;
      shadow_norm[it.plane_idx][2] = it.nz;
      shadow_off[it.plane_idx]     = it.offset;
    end
  endtask

  // Box fields of a load are don't-care, so they carry random bits.
  task automatic load_plane(input logic [2:0] idx, input logic [NORM_W-1:0] nx,
                            input logic [NORM_W-1:0] ny, input logic [NORM_W-1:0] nz,
                            input logic [OFFSET_W-1:0] off);
    cull_item_t it;
    it.kind      = afc_pkg::KIND_LOAD;
    it.plane_idx = idx;
    it.nx        = nx;
    it.ny        = ny;
    it.nz        = nz;
    it.offset    = off;
    it.min_x     = $urandom();
    it.min_y     = $urandom();
    it.min_z     = $urandom();
    it.max_x     = $urandom();
    it.max_y     = $urandom();
    it.max_z     = $urandom();
    send_item(it);
  endtask

  task automatic test_box(input logic [COORD_W-1:0] lx, input logic [COORD_W-1:0] ly,
                          input logic [COORD_W-1:0] lz, input logic [COORD_W-1:0] hx,
                          input logic [COORD_W-1:0] hy, input logic [COORD_W-1:0] hz);
    cull_item_t it;
    it.kind      = afc_pkg::KIND_TEST;
    it.plane_idx = 3'($urandom_range(7));
    it.nx        = 16'($urandom());
    it.ny        = 16'($urandom());
    it.nz        = 16'($urandom());
    it.offset    = $urandom();
    it.min_x     = lx;
    it.min_y     = ly;
    it.min_z     = lz;
    it.max_x     = hx;
    it.max_y     = hy;
    it.max_z     = hz;
    send_item(it);
  endtask

  task automatic test_unloaded_planes();
    test_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    test_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
  endtask

  // Left plane keeps x >= 0, right plane keeps x <= 0; touching counts as visible.
  task automatic test_boundary();
    load_plane(PL_LEFT, 16'sd16384, '0, '0, '0);
    load_plane(PL_RIGHT, -16'sd16384, '0, '0, '0);
    test_box(-32'sd10, 32'sd5, 32'sd5, 32'sd0, 32'sd9, 32'sd9);
    test_box(-32'sd10, 32'sd5, 32'sd5, -32'sd1, 32'sd9, 32'sd9);
    test_box(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    test_box(32'sd1, 32'sd0, 32'sd0, 32'sd7, 32'sd0, 32'sd0);
  endtask

  task automatic test_extreme_values();
    load_plane(PL_NEAR, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000);
    load_plane(PL_FAR, 16'h7fff, 16'h7fff, 16'h7fff, 32'h7fff_ffff);
    test_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    test_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    test_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
  endtask

  // A zero normal with a negative offset culls everything, so a stray write would show.
  task automatic test_plane_index_range();
    load_plane(PL_LEFT, '0, '0, '0, '0);
    load_plane(PL_RIGHT, '0, '0, '0, '0);
    load_plane(PL_NEAR, '0, '0, '0, '0);
    load_plane(PL_FAR, '0, '0, '0, '0);
    load_plane(PL_SPARE6, '0, '0, '0, 32'hffff_ffff);
    load_plane(PL_SPARE7, '0, '0, '0, 32'hffff_ffff);
    test_box(32'sd0, 32'sd0, 32'sd0, 32'sd100, 32'sd100, 32'sd100);
    load_plane(PL_TOP, '0, '0, '0, 32'hffff_ffff);
    test_box(32'sd0, 32'sd0, 32'sd0, 32'sd100, 32'sd100, 32'sd100);
    load_plane(PL_TOP, '0, '0, '0, '0);
  endtask

  // Inverted corners give a negative extent that is used as it stands.
  task automatic test_swapped_corners();
    load_plane(PL_BOTTOM, 16'sd16384, '0, '0, '0);
    test_box(32'sd5, 32'sd0, 32'sd0, -32'sd5, 32'sd0, 32'sd0);
    test_box(32'sd3, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0);
  endtask

  task automatic rand_plane();
    logic [2:0]          idx;
    logic [NORM_W-1:0]   n [AXES];
    logic [OFFSET_W-1:0] off;
    int                  style;
    idx   = 3'(($urandom_range(9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5));
    style = $urandom_range(3);
    for (int a = 0; a < AXES; a++) begin
      case (style)
        0: n[a] = '0;
        1: n[a] = 16'($urandom());
        default: n[a] = 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
    end
    if ($urandom_range(1) == 0) begin
      off = $urandom();
    end else begin
      off = int'($urandom_range(0, 1 << 22)) - (1 << 20);
    end
    load_plane(idx, n[0], n[1], n[2], off);
  endtask

  // Mostly boxes of modest size near the origin, some with full-range or swapped corners.
  task automatic rand_box();
    logic [COORD_W-1:0] lo [AXES];
    logic [COORD_W-1:0] hi [AXES];
    int                 style;
    int                 c;
    int                 e;
    style = $urandom_range(9);
    for (int a = 0; a < AXES; a++) begin
      if (style < 3) begin
        lo[a] = $urandom();
        hi[a] = $urandom();
      end else begin
        c = int'($urandom_range(0, 1 << 22)) - (1 << 21);
        e = $urandom_range(0, 1 << 19);
        lo[a] = (style == 9) ? c + e : c - e;
        hi[a] = (style == 9) ? c - e : c + e;
      end
    end
    test_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  task automatic test_random(input int count, input int sender_idle, input int recv_stall);
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        rand_plane();
      end else begin
        rand_box();
      end
    end
  endtask

  initial begin
    for (int p = 0; p < PLANES; p++) begin
      shadow_off[p] = '0;
      for (int a = 0; a < AXES; a++) shadow_norm[p][a] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unloaded_planes();
    test_boundary();
    test_extreme_values();
    test_plane_index_range();
    test_swapped_corners();
    test_random(PHASE_LEN, 0, 0);
    test_random(PHASE_LEN, 53, 0);
    test_random(PHASE_LEN, 0, 53);
    test_random(PHASE_LEN, 13, 13);

    in_valid_i <= 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    while (expected_visible.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS aabb_frustum_cull");
    end else begin
      $display("FAIL aabb_frustum_cull");
    end
    $finish;
  end

endmodule
